>>> design/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants for the dual interval timer
// Bus addresses, item mode codes and the command struct for one timer.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CYCLE_W = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SRC_W   = 2;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [ADDR_W-1:0] ADDR_TA_LO = 16'hdd04;
  localparam logic [ADDR_W-1:0] ADDR_TA_HI = 16'hdd05;
  localparam logic [ADDR_W-1:0] ADDR_TB_LO = 16'hdd06;
  localparam logic [ADDR_W-1:0] ADDR_TB_HI = 16'hdd07;
  localparam logic [ADDR_W-1:0] ADDR_ICR   = 16'hdd0d;
  localparam logic [ADDR_W-1:0] ADDR_CRA   = 16'hdd0e;
  localparam logic [ADDR_W-1:0] ADDR_CRB   = 16'hdd0f;

  // control register bits
  localparam int unsigned CR_START = 0;
  localparam int unsigned CR_LOAD  = 4;
  localparam int unsigned ICR_SET  = 7;

  typedef struct packed {
    logic               tick;
    logic               wr_lo;
    logic               wr_hi;
    logic               wr_ctl;
    logic [DATA_W-1:0]  wdata;
    logic [SRC_W-1:0]   src;
    logic [CYCLE_W-1:0] elapsed;
  } tmr_cmd_t;

endpackage

>>> design/cia_dual_interval_timer.sv
// ----------------------------------------------------------------------------
// cia_dual_interval_timer: two CIA-style interval timers on an item stream
// Input register, address decode, two timer units and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one item per handshake, a tick (absolute cycle
//   count), a bus read or a bus write. Result channel (out_*): exactly one
//   result per item, in order: read byte, NMI flags of timers A and B, and
//   the pass-to-memory flag.
//   An accepted item passes the input register, then the result register,
//   before out_valid shows its result. Throughput: one item per cycle while
//   the receiver does not stall; state is updated as an item moves from the
//   input register into the result register, so the next item sees it at
//   once.
//   Reset (rst_n low at a clock edge): timers stopped, counts, latches,
//   NMI enables and the last cycle count cleared, both channels empty.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, and in_stall rises only while both are full.
// ----------------------------------------------------------------------------
module cia_dual_interval_timer
  import cia_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [DATA_W-1:0]  in_write_data,
  input  logic [CYCLE_W-1:0] in_cycle_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_read_data,
  output logic               out_nmi_from_a,
  output logic               out_nmi_from_b,
  output logic               out_pass_to_memory
);

  logic               item_vld_r, item_vld_nxt;
  mode_t              mode_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [DATA_W-1:0]  wdata_r;
  logic [CYCLE_W-1:0] cyc_r;

  logic               out_vld_r, out_vld_nxt;
  logic [DATA_W-1:0]  rd_r, rd_nxt;
  logic               nmi_a_r, nmi_a_nxt;
  logic               nmi_b_r, nmi_b_nxt;
  logic               pass_r, pass_nxt;

  logic               nmi_en_a_r, nmi_en_a_nxt;
  logic               nmi_en_b_r, nmi_en_b_nxt;
  logic [CYCLE_W-1:0] last_cyc_r, last_cyc_nxt;

  logic               adv, acc;
  logic               is_tick, is_read, is_write;
  tmr_cmd_t           cmd_a, cmd_b;
  logic [CNT_W-1:0]   count_a, count_b;
  logic               uflow_a, uflow_b;

  assign adv      = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && !adv;
  assign acc      = in_valid && !in_stall;

  assign is_tick  = adv && (mode_r == MODE_TICK);
  assign is_read  = (mode_r == MODE_READ);
  assign is_write = adv && (mode_r == MODE_WRITE);

  always_comb begin
    cmd_a         = '0;
    cmd_a.tick    = is_tick;
    cmd_a.elapsed = cyc_r - last_cyc_r;
    cmd_a.wdata   = wdata_r;
    cmd_a.wr_lo   = is_write && (addr_r == ADDR_TA_LO);
    cmd_a.wr_hi   = is_write && (addr_r == ADDR_TA_HI);
    cmd_a.wr_ctl  = is_write && (addr_r == ADDR_CRA);
    cmd_a.src     = {1'b0, wdata_r[5]};

    cmd_b         = cmd_a;
    cmd_b.wr_lo   = is_write && (addr_r == ADDR_TB_LO);
    cmd_b.wr_hi   = is_write && (addr_r == ADDR_TB_HI);
    cmd_b.wr_ctl  = is_write && (addr_r == ADDR_CRB);
    cmd_b.src     = wdata_r[6:5];
  end

  cia_tmr u_tmr_a (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_a),
    .count (count_a),
    .uflow (uflow_a)
  );

  cia_tmr u_tmr_b (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_b),
    .count (count_b),
    .uflow (uflow_b)
  );

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (acc) begin
      item_vld_nxt = 1'b1;
    end else if (adv) begin
      item_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end

    nmi_en_a_nxt = nmi_en_a_r;
    nmi_en_b_nxt = nmi_en_b_r;
    if (is_write && (addr_r == ADDR_ICR) && wdata_r[ICR_SET]) begin
      nmi_en_a_nxt = wdata_r[0];
      nmi_en_b_nxt = wdata_r[1];
    end

    last_cyc_nxt = is_tick ? cyc_r : last_cyc_r;

    rd_nxt    = '0;
    pass_nxt  = 1'b0;
    nmi_a_nxt = is_tick && uflow_a && nmi_en_a_r;
    nmi_b_nxt = is_tick && uflow_b && nmi_en_b_r;
    if (is_read) begin
      case (addr_r)
        ADDR_TA_LO: rd_nxt = count_a[DATA_W-1:0];
        ADDR_TA_HI: rd_nxt = count_a[CNT_W-1:DATA_W];
        ADDR_TB_LO: rd_nxt = count_b[DATA_W-1:0];
        ADDR_TB_HI: rd_nxt = count_b[CNT_W-1:DATA_W];
        default:    pass_nxt = 1'b1;
      endcase
    end else if (mode_r == MODE_WRITE) begin
      case (addr_r)
        ADDR_TA_LO, ADDR_TA_HI, ADDR_TB_LO, ADDR_TB_HI: pass_nxt = 1'b0;
        default: pass_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      nmi_en_a_r <= 1'b0;
      nmi_en_b_r <= 1'b0;
      last_cyc_r <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      nmi_en_a_r <= nmi_en_a_nxt;
      nmi_en_b_r <= nmi_en_b_nxt;
      last_cyc_r <= last_cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mode_r  <= mode_t'(in_mode);
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      cyc_r   <= in_cycle_count;
    end
    if (adv) begin
      rd_r    <= rd_nxt;
      nmi_a_r <= nmi_a_nxt;
      nmi_b_r <= nmi_b_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_read_data      = rd_r;
  assign out_nmi_from_a     = nmi_a_r;
  assign out_nmi_from_b     = nmi_b_r;
  assign out_pass_to_memory = pass_r;

endmodule

>>> design/cia_tmr.sv
// ----------------------------------------------------------------------------
// cia_tmr: one 16-bit down timer
// Latch, live count, run and source bits; counts elapsed cycles on a tick
// while running with source 0, reloads from the latch on underflow.
// ----------------------------------------------------------------------------
module cia_tmr
  import cia_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tmr_cmd_t         cmd,
  output logic [CNT_W-1:0] count,
  output logic             uflow
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] latch_r, latch_nxt;
  logic             run_r, run_nxt;
  logic [SRC_W-1:0] src_r, src_nxt;
  logic             expired;

  assign expired = (cmd.elapsed[CYCLE_W-1:CNT_W] != '0) ||
                   (cmd.elapsed[CNT_W-1:0] >= count_r);
  assign uflow   = cmd.tick && run_r && (src_r == '0) && expired;

  always_comb begin
    count_nxt = count_r;
    latch_nxt = latch_r;
    run_nxt   = run_r;
    src_nxt   = src_r;
    if (cmd.tick && run_r && (src_r == '0)) begin
      if (expired) begin
        count_nxt = latch_r;
      end else begin
        count_nxt = count_r - cmd.elapsed[CNT_W-1:0];
      end
    end
    if (cmd.wr_lo) begin
      latch_nxt[DATA_W-1:0] = cmd.wdata;
    end
    if (cmd.wr_hi) begin
      latch_nxt[CNT_W-1:DATA_W] = cmd.wdata;
    end
    if (cmd.wr_ctl) begin
      run_nxt = cmd.wdata[CR_START];
      if (!cmd.wdata[CR_START]) begin
        latch_nxt[CNT_W-1:DATA_W] = '0;
      end
      if (cmd.wdata[CR_LOAD]) begin
        count_nxt = latch_nxt;
      end
      src_nxt = cmd.src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      latch_r <= '0;
      run_r   <= 1'b0;
      src_r   <= '0;
    end else begin
      count_r <= count_nxt;
      latch_r <= latch_nxt;
      run_r   <= run_nxt;
      src_r   <= src_nxt;
    end
  end

  assign count = count_r;

endmodule

>>> dv/cia_dual_interval_timer_tb.sv
// ----------------------------------------------------------------------------
// cia_dual_interval_timer_tb: self-checking bench for the dual interval timer
// Directed items walk the register map, zero and wrapping ticks and the
// idle sources. Random ticks, reads and writes follow with random gaps on the
// input and random stall on the output. A scoreboard predicts every result.
// ----------------------------------------------------------------------------
module cia_dual_interval_timer_tb;
  import cia_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic              na;
    logic              nb;
    logic              pass;
  } timer_result_t;

  class timer_scoreboard;
    timer_result_t      expected_q[$];
    int                 errors = 0;
    logic [CNT_W-1:0]   cnt_a = '0;
    logic [CNT_W-1:0]   cnt_b = '0;
    logic [CNT_W-1:0]   latch_a = '0;
    logic [CNT_W-1:0]   latch_b = '0;
    bit                 run_a = 0;
    bit                 run_b = 0;
    bit [SRC_W-1:0]     src_a = '0;
    bit [SRC_W-1:0]     src_b = '0;
    bit                 en_a = 0;
    bit                 en_b = 0;
    logic [CYCLE_W-1:0] prev_cycle = '0;

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string what);
      if (errors < 200) begin
        $display("ERROR: %s", what);
      end
      errors++;
    endtask

    function bit count_down(inout logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] latch,
                            input logic [CYCLE_W-1:0] elapsed);
      if (elapsed >= {16'h0, cnt}) begin
        cnt = latch;
        return 1'b1;
      end
      cnt = cnt - elapsed[CNT_W-1:0];
      return 1'b0;
    endfunction

    function void apply_control(input logic [DATA_W-1:0] d, inout bit run,
                                inout logic [CNT_W-1:0] cnt, inout logic [CNT_W-1:0] latch);
      run = d[CR_START];
      if (!d[CR_START]) begin
        latch[15:8] = 8'h00;
      end
      if (d[CR_LOAD]) begin
        cnt = latch;
      end
    endfunction

    function void note_input(input logic [1:0] mode, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [CYCLE_W-1:0] cyc);
      timer_result_t      r;
      logic [CYCLE_W-1:0] elapsed;
      r = '0;
      case (mode_t'(mode))
        MODE_TICK: begin
          elapsed = cyc - prev_cycle;
          if (run_a && src_a == '0) begin
            if (count_down(cnt_a, latch_a, elapsed)) r.na = en_a;
          end
          if (run_b && src_b == '0) begin
            if (count_down(cnt_b, latch_b, elapsed)) r.nb = en_b;
          end
          prev_cycle = cyc;
        end
        MODE_READ: begin
          case (addr)
            ADDR_TA_LO: r.rd = cnt_a[7:0];
            ADDR_TA_HI: r.rd = cnt_a[15:8];
            ADDR_TB_LO: r.rd = cnt_b[7:0];
            ADDR_TB_HI: r.rd = cnt_b[15:8];
            default:    r.pass = 1'b1;
          endcase
        end
        MODE_WRITE: begin
          case (addr)
            ADDR_TA_LO: latch_a[7:0]  = data;
            ADDR_TA_HI: latch_a[15:8] = data;
            ADDR_TB_LO: latch_b[7:0]  = data;
            ADDR_TB_HI: latch_b[15:8] = data;
            ADDR_ICR: begin
              if (data[ICR_SET]) begin
                en_a = data[0];
                en_b = data[1];
              end
              r.pass = 1'b1;
            end
            ADDR_CRA: begin
              apply_control(data, run_a, cnt_a, latch_a);
              src_a = {1'b0, data[5]};
              r.pass = 1'b1;
            end
            ADDR_CRB: begin
              apply_control(data, run_b, cnt_b, latch_b);
              src_b = data[6:5];
              r.pass = 1'b1;
            end
            default: r.pass = 1'b1;
          endcase
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task check_result(input timer_result_t got);
      timer_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no item pending: rd %0h na %0b nb %0b pass %0b",
                         got.rd, got.na, got.nb, got.pass));
      end else begin
        want = expected_q.pop_front();
        if (got.rd !== want.rd)
          report($sformatf("read_data %0h, expected %0h", got.rd, want.rd));
        if (got.na !== want.na)
          report($sformatf("nmi_from_a %0b, expected %0b", got.na, want.na));
        if (got.nb !== want.nb)
          report($sformatf("nmi_from_b %0b, expected %0b", got.nb, want.nb));
        if (got.pass !== want.pass)
          report($sformatf("pass_to_memory %0b, expected %0b", got.pass, want.pass));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = '0;
  logic [ADDR_W-1:0]  in_address = '0;
  logic [DATA_W-1:0]  in_write_data = '0;
  logic [CYCLE_W-1:0] in_cycle_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DATA_W-1:0]  out_read_data;
  logic               out_nmi_from_a;
  logic               out_nmi_from_b;
  logic               out_pass_to_memory;

  timer_scoreboard    sb;
  logic [CYCLE_W-1:0] tick_cycle = '0;
  int                 burst_left = 0;

  cia_dual_interval_timer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_cycle_count     (in_cycle_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_nmi_from_a     (out_nmi_from_a),
    .out_nmi_from_b     (out_nmi_from_b),
    .out_pass_to_memory (out_pass_to_memory)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_read_data, out_nmi_from_a, out_nmi_from_b, out_pass_to_memory});
      end
      if (in_valid && !in_stall) begin
        sb.note_input(in_mode, in_address, in_write_data, in_cycle_count);
      end
    end
  end

  // output stall: mostly short bursts, a few long ones, and quiet stretches
  initial begin
    int free_len;
    int stall_len;
    @(posedge clk);
    forever begin
      free_len  = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      stall_len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      out_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  task automatic send_item(input mode_t m, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d, input logic [CYCLE_W-1:0] c);
    int gap;
    int r;
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_address     <= a;
    in_write_data  <= d;
    in_cycle_count <= c;
    do @(posedge clk); while (in_stall);
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 2) begin
      burst_left = $urandom_range(20, 80);
      gap = 0;
    end else if (r < 60) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else if (r < 98) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(15, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int                 r;
    int                 s;
    logic [ADDR_W-1:0]  a;
    logic [DATA_W-1:0]  d;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register map after reset, then extremes of latch, zero count and wrap
    send_item(MODE_READ, ADDR_TA_LO, 8'h00, 32'hffff_ffff);
    send_item(MODE_READ, ADDR_TA_HI, 8'hff, 32'h0000_0000);
    send_item(MODE_READ, ADDR_TB_LO, 8'h00, 32'hffff_ffff);
    send_item(MODE_READ, ADDR_TB_HI, 8'hff, 32'h0000_0000);
    send_item(MODE_READ, 16'h0000, 8'h00, 32'h0000_0000);
    send_item(MODE_READ, 16'hffff, 8'hff, 32'hffff_ffff);
    send_item(MODE_WRITE, ADDR_ICR, 8'h7f, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_ICR, 8'h83, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_TA_LO, 8'hff, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_TA_HI, 8'hff, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_TB_LO, 8'h00, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_TB_HI, 8'h00, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_CRA, 8'h11, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_CRB, 8'h11, 32'h0000_0000);
    send_item(MODE_TICK, 16'h0000, 8'h00, 32'h0000_0000);
    send_item(MODE_TICK, 16'hffff, 8'hff, 32'hffff_ffff);
    send_item(MODE_TICK, 16'h0000, 8'h00, 32'h0000_0005);
    send_item(MODE_READ, ADDR_TA_LO, 8'h00, 32'h0000_0000);
    send_item(MODE_READ, ADDR_TA_HI, 8'h00, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_CRA, 8'h10, 32'h0000_0000);
    send_item(MODE_WRITE, ADDR_CRB, 8'h61, 32'h0000_0000);
    send_item(MODE_TICK, 16'h0000, 8'h00, 32'h0000_0100);
    send_item(MODE_WRITE, ADDR_CRB, 8'h21, 32'h0000_0000);
    send_item(MODE_TICK, 16'h0000, 8'h00, 32'h0000_0200);
    send_item(MODE_WRITE, 16'hffff, 8'hff, 32'hffff_ffff);
    send_item(MODE_NONE, ADDR_TA_LO, 8'hff, 32'hffff_ffff);
    send_item(MODE_WRITE, ADDR_ICR, 8'h80, 32'h0000_0000);
    send_item(MODE_READ, ADDR_TA_LO, 8'h00, 32'h0000_0000);
    tick_cycle = 32'h0000_0200;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < 40) begin
        if (s < 70) tick_cycle += $urandom_range(0, 40);
        else if (s < 85) tick_cycle += $urandom_range(41, 600);
        else if (s < 95) tick_cycle += $urandom_range(0, 70000);
        else tick_cycle = $urandom;
        send_item(MODE_TICK, 16'($urandom), 8'($urandom), tick_cycle);
      end else if (r < 60) begin
        if (s < 80) a = 16'(ADDR_TA_LO + $urandom_range(0, 3));
        else if (s < 90) a = 16'(16'hdd00 + $urandom_range(0, 15));
        else a = 16'($urandom);
        send_item(MODE_READ, a, 8'($urandom), 32'($urandom));
      end else if (r < 95) begin
        d = 8'($urandom);
        if (s < 30) begin
          // latch bytes: high byte mostly tiny so that timers underflow often
          a = 16'(ADDR_TA_LO + $urandom_range(0, 3));
          if (a[0] && $urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 1));
        end else if (s < 60) begin
          a = $urandom_range(0, 1) ? ADDR_CRA : ADDR_CRB;
          if ($urandom_range(0, 4) != 0) d[CR_START] = 1'b1;
          if ($urandom_range(0, 3) != 0) d[6:5] = 2'b00;
        end else if (s < 75) begin
          a = ADDR_ICR;
        end else if (s < 85) begin
          a = 16'(16'hdd00 + $urandom_range(0, 15));
        end else begin
          a = 16'($urandom);
        end
        send_item(MODE_WRITE, a, d, 32'($urandom));
      end else begin
        send_item(mode_t'(2'($urandom_range(0, 3))), 16'($urandom), 8'($urandom),
                  32'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/cia_pkg.sv
design/cia_tmr.sv
design/cia_dual_interval_timer.sv
dv/cia_dual_interval_timer_tb.sv
